@@ hw/rtl/tts_pkg.sv @@
// ----------------------------------------------------------------------------
// Task table scheduler package
// Sizes, command codes, cell operations and the structs passed along the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = $clog2(MAX_TASKS);
	localparam int CNT_W     = 4;
	localparam int PRIO_W    = 4;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_CREATE = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] CFG_POLICY_MODE = 2'd0;
	localparam logic [1:0] CFG_SJF_REFILL  = 2'd1;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DEC,
		OP_CREATE,
		OP_CLEAR,
		OP_REFILL
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  slot;
		logic [PRIO_W-1:0] prio;
		logic              mode;
		logic [CNT_W-1:0]  refill;
	} cell_ctrl_t;

	typedef struct packed {
		logic              vld;
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic [CNT_W-1:0]  cnt;
		logic              free_found;
		logic [IDX_W-1:0]  free_idx;
	} scan_t;

endpackage

`default_nettype wire

@@ hw/rtl/tts_cell.sv @@
// ----------------------------------------------------------------------------
// Task table scheduler cell
// One task slot: valid flag, priority and slice counter, plus one scan stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [tts_pkg::IDX_W-1:0]    my_idx,
	input  wire  tts_pkg::cell_ctrl_t    ctrl,
	input  wire  tts_pkg::scan_t         scan_in,
	output tts_pkg::scan_t               scan_out,
	output logic                         valid,
	output logic [tts_pkg::CNT_W-1:0]    cnt
);
	import tts_pkg::*;

	logic              valid_q;
	logic [PRIO_W-1:0] prio_q;
	logic [CNT_W-1:0]  cnt_q;
	scan_t             scan_s1;
	logic              hit;
	logic              usable;
	logic              take;
	scan_t             scan_nx;

	assign hit    = (ctrl.slot == my_idx);
	assign usable = valid_q && (cnt_q != '0);
	assign take   = usable && (!scan_in.found ||
		(ctrl.mode ? (cnt_q > scan_in.cnt) : (cnt_q < scan_in.cnt)));

	always_comb begin
		scan_nx = scan_in;
		if (take) begin
			scan_nx.found = 1'b1;
			scan_nx.idx   = my_idx;
			scan_nx.cnt   = cnt_q;
		end
		if (!scan_in.free_found && !valid_q) begin
			scan_nx.free_found = 1'b1;
			scan_nx.free_idx   = my_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			prio_q  <= '0;
			cnt_q   <= '0;
			scan_s1 <= '0;
		end else begin
			scan_s1 <= scan_nx;
			case (ctrl.op)
				OP_DEC: begin
					if (hit && cnt_q != '0) cnt_q <= cnt_q - 1'b1;
				end
				OP_CREATE: begin
					if (hit) begin
						valid_q <= 1'b1;
						prio_q  <= ctrl.prio;
						cnt_q   <= '0;
					end
				end
				OP_CLEAR: begin
					if (hit) begin
						valid_q <= 1'b0;
						prio_q  <= '0;
						cnt_q   <= '0;
					end
				end
				OP_REFILL: begin
					if (valid_q) cnt_q <= ctrl.mode ? prio_q : ctrl.refill;
				end
				default: begin
				end
			endcase
		end
	end

	assign scan_out = scan_s1;
	assign valid    = valid_q;
	assign cnt      = cnt_q;

endmodule

`default_nettype wire

@@ hw/rtl/tts_ctrl.sv @@
// ----------------------------------------------------------------------------
// Task table scheduler control
// Command sequencer: drives cell operations, starts scans, builds results.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ctrl (
	input  wire                                           clk,
	input  wire                                           arst_n,
	input  wire                                           policy_mode,
	input  wire  [tts_pkg::CNT_W-1:0]                     sjf_refill_count,
	input  wire                                           s_axis_tvalid,
	output logic                                          s_axis_tready,
	input  wire  [7:0]                                    s_axis_tdata,
	input  wire  [1:0]                                    s_axis_tuser,
	output logic                                          m_axis_tvalid,
	input  wire                                           m_axis_tready,
	output logic [15:0]                                   m_axis_tdata,
	output tts_pkg::cell_ctrl_t                           ctrl,
	output tts_pkg::scan_t                                scan_head,
	input  wire  tts_pkg::scan_t                          scan_tail,
	input  wire  [tts_pkg::MAX_TASKS-1:0]                 cell_valid,
	input  wire  [tts_pkg::MAX_TASKS-1:0][tts_pkg::CNT_W-1:0] cell_cnt
);
	import tts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_SCAN,
		S_REFILL,
		S_DONE
	} state_t;

	state_t            state_q;
	cell_op_t          op_q;
	logic [IDX_W-1:0]  op_slot_q;
	logic [PRIO_W-1:0] prio_q;
	logic              inject_q;
	logic              create_q;
	logic              second_q;
	logic              zero_q;
	logic              idle_q;
	logic [IDX_W-1:0]  run_q;
	logic              old_idle_q;
	logic [IDX_W-1:0]  old_run_q;
	logic [IDX_W-1:0]  created_q;
	logic              full_q;
	logic              out_vld_q;
	logic [15:0]       out_data_q;

	logic              in_xfer;
	logic [1:0]        in_cmd;
	logic [3:0]        in_prio;
	logic [3:0]        in_slot;
	logic [IDX_W-1:0]  rm_idx;
	logic              rm_ok;
	logic [CNT_W-1:0]  run_cnt;
	logic              switched;
	logic [4:0]        run_task;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign in_cmd        = s_axis_tuser;
	assign in_prio       = s_axis_tdata[3:0];
	assign in_slot       = s_axis_tdata[7:4];
	assign rm_idx        = IDX_W'(in_slot);
	assign rm_ok         = (int'(in_slot) < MAX_TASKS) && cell_valid[rm_idx];
	assign run_cnt       = cell_cnt[run_q];

	assign switched = (old_idle_q != idle_q) || (!idle_q && old_run_q != run_q);
	assign run_task = idle_q ? 5'd0 : 5'(32'(run_q) + 32'd1);

	assign ctrl.op     = op_q;
	assign ctrl.slot   = op_slot_q;
	assign ctrl.prio   = prio_q;
	assign ctrl.mode   = policy_mode;
	assign ctrl.refill = sjf_refill_count;

	always_comb begin
		scan_head     = '0;
		scan_head.vld = inject_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_NONE;
			op_slot_q  <= '0;
			prio_q     <= '0;
			inject_q   <= 1'b0;
			create_q   <= 1'b0;
			second_q   <= 1'b0;
			zero_q     <= 1'b0;
			idle_q     <= 1'b1;
			run_q      <= '0;
			old_idle_q <= 1'b1;
			old_run_q  <= '0;
			created_q  <= '0;
			full_q     <= 1'b0;
			out_vld_q  <= 1'b0;
			out_data_q <= '0;
		end else begin
			op_q     <= OP_NONE;
			inject_q <= 1'b0;
			if (out_vld_q && m_axis_tready) out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						old_idle_q <= idle_q;
						old_run_q  <= run_q;
						created_q  <= '0;
						full_q     <= 1'b0;
						create_q   <= 1'b0;
						second_q   <= 1'b0;
						prio_q     <= in_prio;
						state_q    <= S_DONE;
						case (in_cmd)
							CMD_TICK: begin
								if (idle_q) begin
									inject_q <= 1'b1;
									state_q  <= S_SCAN;
								end else begin
									op_q      <= OP_DEC;
									op_slot_q <= run_q;
									zero_q    <= (run_cnt <= CNT_W'(1));
									state_q   <= S_DEC;
								end
							end
							CMD_CREATE: begin
								inject_q <= 1'b1;
								create_q <= 1'b1;
								state_q  <= S_SCAN;
							end
							CMD_REMOVE: begin
								if (rm_ok) begin
									op_q      <= OP_CLEAR;
									op_slot_q <= rm_idx;
									if (!idle_q && run_q == rm_idx) begin
										idle_q <= 1'b1;
										run_q  <= '0;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DEC: begin
					if (zero_q) begin
						inject_q <= 1'b1;
						state_q  <= S_SCAN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (scan_tail.vld) begin
						state_q <= S_DONE;
						if (create_q) begin
							if (scan_tail.free_found) begin
								op_q      <= OP_CREATE;
								op_slot_q <= scan_tail.free_idx;
								created_q <= scan_tail.free_idx;
							end else begin
								full_q <= 1'b1;
							end
						end else if (scan_tail.found) begin
							idle_q <= 1'b0;
							run_q  <= scan_tail.idx;
						end else if (!second_q) begin
							op_q    <= OP_REFILL;
							state_q <= S_REFILL;
						end else begin
							idle_q <= 1'b1;
							run_q  <= '0;
						end
					end
				end
				S_REFILL: begin
					second_q <= 1'b1;
					inject_q <= 1'b1;
					state_q  <= S_SCAN;
				end
				S_DONE: begin
					if (!out_vld_q || m_axis_tready) begin
						out_vld_q  <= 1'b1;
						out_data_q <= {5'd0, full_q, 4'(created_q), switched, run_task};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	a_scan_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_tail.vld |-> state_q == S_SCAN)
		else $error("scan result outside scan state");

	a_single_inject: assert property (@(posedge clk) disable iff (!arst_n)
		inject_q |=> !inject_q)
		else $error("scan injected on two cycles in a row");

	a_running_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !idle_q) |-> cell_valid[run_q])
		else $error("running slot holds no task");

	a_full_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_data_q[10]) |-> out_data_q[9:6] == 4'd0)
		else $error("full table reported with a created slot");

endmodule

`default_nettype wire

@@ hw/rtl/task_table_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// Task table scheduler top level
// Time-slice scheduler over a chain of task slot cells.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the command (tick, create, remove), tdata the
// priority of a created task and the slot to remove. Every input transfer
// yields exactly one output transfer with the running task (0 idle, else
// slot plus one), a switched flag, the created slot and a table-full flag.
// Configuration writes go over cfg_valid/cfg_ready (always ready) and are
// to be made by the user only while no command is in flight; the block
// itself does not enforce it. Remove and unused commands go straight to
// the result, a tick without reschedule through the decrement state first,
// a create or a tick from idle makes one pass of the scan through the
// MAX_TASKS cells, a tick that ends the running slice decrements before its
// pass, and a tick needing a refill makes two passes with a refill between
// them, decrementing first when it ends the running slice.
// One command is worked on at a time; the next may be taken while the
// previous result waits in the output register. If the receiver stalls, the
// finished result holds and a further result waits until it drains.
// Reset empties the table, idles the scheduler and restores the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module task_table_scheduler_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [3:0]  cfg_data,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // task_priority[3:0], slot_index[7:4]
	input  wire  [1:0]  s_axis_tuser,   // cmd[1:0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata    // running_task[4:0], switched[5],
	                                    // created_slot[9:6], table_full[10]
);
	import tts_pkg::*;

	logic                            policy_mode_q;
	logic [CNT_W-1:0]                sjf_refill_q;
	cell_ctrl_t                      ctrl;
	scan_t                           chain [MAX_TASKS+1];
	logic [MAX_TASKS-1:0]            cell_valid;
	logic [MAX_TASKS-1:0][CNT_W-1:0] cell_cnt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_mode_q <= 1'b1;
			sjf_refill_q  <= CNT_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_POLICY_MODE: policy_mode_q <= cfg_data[0];
				CFG_SJF_REFILL:  sjf_refill_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tts_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.policy_mode      (policy_mode_q),
		.sjf_refill_count (sjf_refill_q),
		.s_axis_tvalid    (s_axis_tvalid),
		.s_axis_tready    (s_axis_tready),
		.s_axis_tdata     (s_axis_tdata),
		.s_axis_tuser     (s_axis_tuser),
		.m_axis_tvalid    (m_axis_tvalid),
		.m_axis_tready    (m_axis_tready),
		.m_axis_tdata     (m_axis_tdata),
		.ctrl             (ctrl),
		.scan_head        (chain[0]),
		.scan_tail        (chain[MAX_TASKS]),
		.cell_valid       (cell_valid),
		.cell_cnt         (cell_cnt)
	);

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		tts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.my_idx   (IDX_W'(i)),
			.ctrl     (ctrl),
			.scan_in  (chain[i]),
			.scan_out (chain[i+1]),
			.valid    (cell_valid[i]),
			.cnt      (cell_cnt[i])
		);
	end

endmodule

`default_nettype wire
